// ===== design/cfm_pkg.sv =====
// shared types, constants and helpers of the counter frequency meter
package cfm_pkg;

	// field widths
	localparam int VAL_W   = 64;
	localparam int TIME_W  = 32;
	localparam int FREQ_W  = 15;
	localparam int DELTA_W = 17;
	localparam int PROD_W  = 27;
	localparam int DIVR_W  = 11;
	localparam int IDX_W   = 2;
	localparam int REG_W   = 3;
	localparam int CFG_CNT = 4;

	// digit-serial datapath geometry
	localparam int DIG_W      = 4;
	localparam int SER_STEPS  = VAL_W / DIG_W;
	localparam int TIME_STEPS = TIME_W / DIG_W;
	localparam int LO_STEPS   = (DELTA_W + DIG_W - 1) / DIG_W;
	localparam int LO_W       = LO_STEPS * DIG_W;
	localparam int STEP_W     = $clog2(SER_STEPS);
	localparam int DSTEP_W    = $clog2(PROD_W);

	// request codes
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// register indexes
	localparam logic [REG_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [REG_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [REG_W-1:0] REG_DOWN   = 3'd2;
	localparam logic [REG_W-1:0] REG_START0 = 3'd3;
	localparam logic [REG_W-1:0] REG_START1 = 3'd4;
	localparam logic [REG_W-1:0] REG_START2 = 3'd5;
	localparam logic [REG_W-1:0] REG_START3 = 3'd6;

	// width codes
	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;

	// window and limit constants
	localparam logic [TIME_W-1:0] WIN_MIN_MS  = 32'd1000;
	localparam logic [TIME_W-1:0] WIN_MAX_MS  = 32'd2000;
	localparam logic [TIME_W-1:0] RESTART_MS  = 32'd5000;
	localparam logic [VAL_W-1:0]  DELTA_LIMIT = 64'd100000;
	localparam logic [FREQ_W-1:0] FREQ_MAX    = 15'd20000;
	localparam logic [PROD_W-1:0] SCALE_MULT  = 27'd1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SERIAL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] counter_id;
		logic [VAL_W-1:0] count_value;
		logic [TIME_W-1:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq_hz;
		logic              window_valid;
		logic [TIME_W-1:0] elapsed_ms;
	} out_word_t;

	typedef struct packed {
		logic [REG_W-1:0] index;
		logic [VAL_W-1:0] wdata;
	} cfg_word_t;

	// operands handed to the serial delta engine
	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [VAL_W-1:0]  last;
		logic [VAL_W-1:0]  wrap_base;
		logic              down;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] then_ms;
	} ser_req_t;

	typedef struct packed {
		logic [DELTA_W-1:0] delta;
		logic               delta_ok;
		logic [TIME_W-1:0]  dt;
	} ser_res_t;

	typedef struct packed {
		logic [PROD_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	// largest value of an up counter of the given width code
	function automatic logic [VAL_W-1:0] wrap_max(input logic [1:0] code);
		logic [VAL_W-1:0] m;
		case (code)
			WC_8:    m = 64'h0000_0000_0000_00FF;
			WC_16:   m = 64'h0000_0000_0000_FFFF;
			WC_32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// ===== design/cfm_stream_if.sv =====
// valid/ready channel carrying one word per handshake
interface cfm_stream_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== design/cfm_serial_delta.sv =====
// digit-serial count delta, wrap sanity check and elapsed time engine
module cfm_serial_delta (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cfm_pkg::ser_req_t req,
	output logic              done,
	output cfm_pkg::ser_res_t res
);
	localparam int DW = cfm_pkg::DIG_W;

	logic                           busy_q;
	logic                           done_q;
	logic [cfm_pkg::STEP_W-1:0]     step_q;
	logic [cfm_pkg::VAL_W-1:0]      a_q;
	logic [cfm_pkg::VAL_W-1:0]      b_q;
	logic [cfm_pkg::VAL_W-1:0]      k_q;
	logic [cfm_pkg::VAL_W-1:0]      lim_q;
	logic [cfm_pkg::TIME_W-1:0]     now_q;
	logic [cfm_pkg::TIME_W-1:0]     then_q;
	logic [cfm_pkg::TIME_W-1:0]     dt_q;
	logic [cfm_pkg::LO_W-1:0]       dlo_q;
	logic [cfm_pkg::LO_W-1:0]       wlo_q;
	logic                           down_q;
	logic                           bor_q;
	logic                           car_q;
	logic                           tbor_q;
	logic                           gtw_q;
	logic                           gtd_lim_q;
	logic                           gtw_lim_q;
	logic                           knz_q;

	logic [DW:0]   diff;
	logic [DW:0]   sum;
	logic [DW:0]   tdiff;
	logic [DW-1:0] ddig;
	logic [DW-1:0] wdig;
	logic [DW-1:0] kdig;
	logic [DW-1:0] hdig;
	logic [DW-1:0] ldig;
	logic          last_step;
	logic          sane;

	always_comb begin
		kdig  = k_q[DW-1:0];
		hdig  = k_q[DW:1];
		ldig  = lim_q[DW-1:0];
		diff  = {1'b0, a_q[DW-1:0]} - {1'b0, b_q[DW-1:0]} - {{DW{1'b0}}, bor_q};
		ddig  = diff[DW-1:0];
		// wrapped delta adds the wrap base plus one
		sum   = {1'b0, ddig} + {1'b0, kdig} + {{DW{1'b0}}, car_q};
		wdig  = sum[DW-1:0];
		tdiff = {1'b0, now_q[DW-1:0]} - {1'b0, then_q[DW-1:0]} - {{DW{1'b0}}, tbor_q};
		last_step = step_q == cfm_pkg::STEP_W'(cfm_pkg::SER_STEPS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q       <= req.down ? req.last : req.value;
			b_q       <= req.down ? req.value : req.last;
			k_q       <= req.wrap_base;
			lim_q     <= cfm_pkg::DELTA_LIMIT;
			now_q     <= req.now_ms;
			then_q    <= req.then_ms;
			down_q    <= req.down;
			bor_q     <= 1'b0;
			car_q     <= 1'b1;
			tbor_q    <= 1'b0;
			gtw_q     <= 1'b0;
			gtd_lim_q <= 1'b0;
			gtw_lim_q <= 1'b0;
			knz_q     <= 1'b0;
		end else if (busy_q) begin
			a_q       <= a_q >> DW;
			b_q       <= b_q >> DW;
			k_q       <= k_q >> DW;
			lim_q     <= lim_q >> DW;
			now_q     <= now_q >> DW;
			then_q    <= then_q >> DW;
			bor_q     <= diff[DW];
			car_q     <= sum[DW];
			tbor_q    <= tdiff[DW];
			// compares run lsb first, a higher digit overrides
			gtw_q     <= (wdig > hdig) || ((wdig == hdig) && gtw_q);
			gtd_lim_q <= (ddig > ldig) || ((ddig == ldig) && gtd_lim_q);
			gtw_lim_q <= (wdig > ldig) || ((wdig == ldig) && gtw_lim_q);
			knz_q     <= knz_q || (|kdig);
			if (step_q < cfm_pkg::STEP_W'(cfm_pkg::TIME_STEPS)) begin
				dt_q <= {tdiff[DW-1:0], dt_q[cfm_pkg::TIME_W-1:DW]};
			end
			if (step_q < cfm_pkg::STEP_W'(cfm_pkg::LO_STEPS)) begin
				dlo_q <= {ddig, dlo_q[cfm_pkg::LO_W-1:DW]};
				wlo_q <= {wdig, wlo_q[cfm_pkg::LO_W-1:DW]};
			end
		end
	end

	// final borrow means the counter passed its wrap point
	always_comb begin
		sane         = !(gtw_q && (!down_q || knz_q));
		res.delta_ok = bor_q ? (sane && !gtw_lim_q) : !gtd_lim_q;
		res.delta    = bor_q ? wlo_q[cfm_pkg::DELTA_W-1:0] : dlo_q[cfm_pkg::DELTA_W-1:0];
		res.dt       = dt_q;
		done         = done_q;
	end

endmodule

// ===== design/cfm_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module cfm_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  cfm_pkg::div_req_t             req,
	output logic                          done,
	output logic [cfm_pkg::PROD_W-1:0]    quotient
);
	localparam int NW = cfm_pkg::PROD_W;
	localparam int DW = cfm_pkg::DIVR_W;

	logic                        busy_q;
	logic                        done_q;
	logic [cfm_pkg::DSTEP_W-1:0] cnt_q;
	logic [DW-1:0]               rem_q;
	logic [DW-1:0]               dsr_q;
	logic [NW-1:0]               quo_q;

	logic [DW:0] rem_sh;
	logic [DW:0] rem_nx;
	logic        ge;
	logic        last_step;

	always_comb begin
		rem_sh    = {rem_q, quo_q[NW-1]};
		ge        = rem_sh >= {1'b0, dsr_q};
		rem_nx    = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
		last_step = cnt_q == cfm_pkg::DSTEP_W'(NW - 1);
		done      = done_q;
		quotient  = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

endmodule

// ===== design/counter_frequency_meter_unit.sv =====
// top level of the gated frequency meter for a bank of counters
// Each request word names a counter and is either a sample update, a clear or
// a query; every request gives exactly one response word holding the counter's
// frequency, its window-valid flag and the time since its last measurement.
// A sample that lands 1000 to 2000 ms after the previous measurement forms the
// count delta (up or down, wrapped at the counter width or reload value, with a
// half-range sanity check) and, for a sane delta up to 100000, sets the
// frequency to delta*1000/elapsed, saturated at 20000 Hz; after more than
// 5000 ms tracking restarts. One request is in work at a time. Every request
// moves the 64-bit count through a 4-bit serial datapath in 16 steps; a sample
// that closes a window then runs the radix-2 divider, one quotient bit per
// cycle over 27 bits. The response sits in an output register, so the next
// request is accepted while it waits. The config port is always ready; write
// it only while no request is in work.
module counter_frequency_meter_unit #(
	parameter int NUM_COUNTERS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	cfm_stream_if.sink   cfg,
	cfm_stream_if.sink   req,
	cfm_stream_if.source rsp
);
	localparam int CW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

	// configuration registers
	logic [cfm_pkg::CFG_CNT-1:0]            enable_mask_q;
	logic [cfm_pkg::CFG_CNT-1:0][1:0]       width_codes_q;
	logic [cfm_pkg::CFG_CNT-1:0]            down_mask_q;
	logic [cfm_pkg::VAL_W-1:0]              start_value_q [cfm_pkg::CFG_CNT];

	// per counter tracking state
	logic [cfm_pkg::VAL_W-1:0]  last_count_q [NUM_COUNTERS];
	logic [cfm_pkg::TIME_W-1:0] last_time_q  [NUM_COUNTERS];
	logic [cfm_pkg::FREQ_W-1:0] freq_q       [NUM_COUNTERS];
	logic                       valid_q      [NUM_COUNTERS];

	// request held while in work
	logic [1:0]                 req_type_q;
	logic [cfm_pkg::IDX_W-1:0]  cid_q;
	logic [cfm_pkg::VAL_W-1:0]  value_q;
	logic [cfm_pkg::TIME_W-1:0] now_q;

	cfm_pkg::state_t    state_q;
	cfm_pkg::state_t    state_d;
	cfm_pkg::out_word_t out_q;
	cfm_pkg::out_word_t out_d;
	logic               out_full_q;
	logic               out_load;

	// shared read port of the state arrays
	logic [cfm_pkg::IDX_W-1:0]  rd_cid;
	logic                       rd_ok;
	logic [CW-1:0]              rd_idx;
	logic [cfm_pkg::VAL_W-1:0]  cnt_rd;
	logic [cfm_pkg::TIME_W-1:0] lt_rd;
	logic [cfm_pkg::FREQ_W-1:0] freq_rd;
	logic                       vld_rd;

	cfm_pkg::ser_req_t  ser_req;
	cfm_pkg::ser_res_t  ser_res;
	logic               ser_start;
	logic               ser_done;
	cfm_pkg::div_req_t  div_req;
	logic               div_start;
	logic               div_done;
	logic [cfm_pkg::PROD_W-1:0] quotient;

	// update decision for the addressed counter
	logic                       in_window;
	logic                       need_div;
	logic                       st_we;
	logic [cfm_pkg::FREQ_W-1:0] sat_freq;
	logic [cfm_pkg::VAL_W-1:0]  nx_cnt;
	logic [cfm_pkg::TIME_W-1:0] nx_lt;
	logic [cfm_pkg::FREQ_W-1:0] nx_freq;
	logic                       nx_vld;

	// config port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= '1;
			width_codes_q <= '1;
			down_mask_q   <= '0;
			for (int i = 0; i < cfm_pkg::CFG_CNT; i++) begin
				start_value_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.word.index)
				cfm_pkg::REG_ENABLE: enable_mask_q    <= cfg.word.wdata[cfm_pkg::CFG_CNT-1:0];
				cfm_pkg::REG_WIDTH:  width_codes_q    <= cfg.word.wdata[2*cfm_pkg::CFG_CNT-1:0];
				cfm_pkg::REG_DOWN:   down_mask_q      <= cfg.word.wdata[cfm_pkg::CFG_CNT-1:0];
				cfm_pkg::REG_START0: start_value_q[0] <= cfg.word.wdata;
				cfm_pkg::REG_START1: start_value_q[1] <= cfg.word.wdata;
				cfm_pkg::REG_START2: start_value_q[2] <= cfg.word.wdata;
				cfm_pkg::REG_START3: start_value_q[3] <= cfg.word.wdata;
				default: ;
			endcase
		end
	end

	// the arrays are read at the incoming id when idle, else at the held id
	always_comb begin
		rd_cid  = (state_q == cfm_pkg::ST_IDLE) ? req.word.counter_id : cid_q;
		rd_ok   = int'(rd_cid) < NUM_COUNTERS;
		rd_idx  = CW'(rd_cid);
		cnt_rd  = rd_ok ? last_count_q[rd_idx] : '0;
		lt_rd   = rd_ok ? last_time_q[rd_idx] : '0;
		freq_rd = rd_ok ? freq_q[rd_idx] : '0;
		vld_rd  = rd_ok ? valid_q[rd_idx] : 1'b0;
	end

	always_comb begin
		ser_req.value     = req.word.count_value;
		ser_req.last      = cnt_rd;
		ser_req.down      = down_mask_q[rd_cid];
		ser_req.wrap_base = down_mask_q[rd_cid] ? start_value_q[rd_cid]
		                                        : cfm_pkg::wrap_max(width_codes_q[rd_cid]);
		ser_req.now_ms    = req.word.now_ms;
		ser_req.then_ms   = lt_rd;
	end

	cfm_serial_delta u_delta (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ser_start),
		.req    (ser_req),
		.done   (ser_done),
		.res    (ser_res)
	);

	// delta is at most 100000 here, so the product fits 27 bits
	always_comb begin
		div_req.dividend = cfm_pkg::PROD_W'(ser_res.delta) * cfm_pkg::SCALE_MULT;
		div_req.divisor  = ser_res.dt[cfm_pkg::DIVR_W-1:0];
	end

	cfm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	// per-request update of the addressed counter
	always_comb begin
		in_window = (ser_res.dt >= cfm_pkg::WIN_MIN_MS) && (ser_res.dt <= cfm_pkg::WIN_MAX_MS);
		need_div  = rd_ok && (req_type_q == cfm_pkg::REQ_SAMPLE) && enable_mask_q[rd_cid]
		            && (lt_rd != '0) && in_window && ser_res.delta_ok;
		sat_freq  = (quotient > cfm_pkg::PROD_W'(cfm_pkg::FREQ_MAX)) ? cfm_pkg::FREQ_MAX
		                                                             : quotient[cfm_pkg::FREQ_W-1:0];
		nx_cnt  = cnt_rd;
		nx_lt   = lt_rd;
		nx_freq = freq_rd;
		nx_vld  = vld_rd;
		st_we   = 1'b0;
		case (req_type_q)
			cfm_pkg::REQ_SAMPLE: begin
				if (enable_mask_q[rd_cid]) begin
					if (lt_rd == '0 || (!in_window && ser_res.dt > cfm_pkg::RESTART_MS)) begin
						// not started yet, or window long lost: start over here
						st_we   = 1'b1;
						nx_cnt  = value_q;
						nx_lt   = now_q;
						nx_freq = '0;
						nx_vld  = 1'b0;
					end else if (in_window) begin
						st_we  = 1'b1;
						nx_cnt = value_q;
						nx_lt  = now_q;
						nx_vld = 1'b1;
						if (ser_res.delta_ok) begin
							nx_freq = sat_freq;
						end
					end
				end
			end
			cfm_pkg::REQ_CLEAR: begin
				st_we   = 1'b1;
				nx_cnt  = '0;
				nx_lt   = '0;
				nx_freq = '0;
				nx_vld  = 1'b0;
			end
			default: ;
		endcase
		if (rd_ok) begin
			out_d.freq_hz      = nx_freq;
			out_d.window_valid = nx_vld;
			out_d.elapsed_ms   = (nx_lt == '0) ? '0 : (now_q - nx_lt);
		end else begin
			out_d = '0;
		end
	end

	// control sequencer
	always_comb begin
		state_d   = state_q;
		ser_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		req.ready = state_q == cfm_pkg::ST_IDLE;
		case (state_q)
			cfm_pkg::ST_IDLE: begin
				if (req.valid) begin
					ser_start = 1'b1;
					state_d   = cfm_pkg::ST_SERIAL;
				end
			end
			cfm_pkg::ST_SERIAL: begin
				if (ser_done) begin
					if (need_div) begin
						div_start = 1'b1;
						state_d   = cfm_pkg::ST_DIV;
					end else begin
						state_d = cfm_pkg::ST_DONE;
					end
				end
			end
			cfm_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = cfm_pkg::ST_DONE;
				end
			end
			cfm_pkg::ST_DONE: begin
				// wait for room in the output register
				if (!out_full_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = cfm_pkg::ST_IDLE;
				end
			end
			default: state_d = cfm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_start) begin
			req_type_q <= req.word.req_type;
			cid_q      <= req.word.counter_id;
			value_q    <= req.word.count_value;
			now_q      <= req.word.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				last_count_q[i] <= '0;
				last_time_q[i]  <= '0;
				freq_q[i]       <= '0;
				valid_q[i]      <= 1'b0;
			end
		end else if (out_load && st_we && rd_ok) begin
			last_count_q[rd_idx] <= nx_cnt;
			last_time_q[rd_idx]  <= nx_lt;
			freq_q[rd_idx]       <= nx_freq;
			valid_q[rd_idx]      <= nx_vld;
		end
	end

	// response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (out_load) begin
			out_full_q <= 1'b1;
		end else if (rsp.ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid = out_full_q;
	assign rsp.word  = out_q;

`ifndef SYNTHESIS
	a_ser_done_in_serial: assert property (@(posedge clk) disable iff (!arst_n)
		ser_done |-> state_q == cfm_pkg::ST_SERIAL)
		else $error("delta engine finished outside the serial phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == cfm_pkg::ST_DIV)
		else $error("divider finished outside the divide phase");

	a_div_window: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (ser_res.dt >= cfm_pkg::WIN_MIN_MS && ser_res.dt <= cfm_pkg::WIN_MAX_MS))
		else $error("divider started with elapsed time outside the window");

	a_freq_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_q.freq_hz <= cfm_pkg::FREQ_MAX)
		else $error("response frequency above saturation limit");
`endif

endmodule
